// ===== hw/rtl/tsf_pkg.sv =====
`default_nettype none
package tsf_pkg;
    localparam int FW = 48;
    localparam int CW = 47;
    localparam int MW = 62;
    localparam int AW = 49;
    localparam int RW = 48;
    localparam int QW = 49;
    localparam int DIVIDEND_LOG2 = 64;
    localparam int SQ_PER = 3;
    localparam int SQ_ST = RW / SQ_PER;
    localparam int DV_PER = 4;
    localparam int DV_ST = (QW + DV_PER - 1) / DV_PER;
    localparam int LAT = 13 + SQ_ST + DV_ST;
    localparam logic [MW-1:0] CAP = {1'b1, {(MW-1){1'b0}}};

    localparam logic [2:0] REG_CORE = 3'd0;
    localparam logic [2:0] REG_MASS = 3'd1;
    localparam logic [2:0] REG_SPX  = 3'd2;
    localparam logic [2:0] REG_SPY  = 3'd3;
    localparam logic [2:0] REG_SPZ  = 3'd4;

    typedef struct packed {
        logic [63:0] ll;
        logic [63:0] lh;
        logic [63:0] hl;
        logic [63:0] hh;
    } t_pp;

    function automatic t_pp mul_pp(input logic [MW-1:0] a, input logic [MW-1:0] b);
        t_pp p;
        p.ll = 64'(a[31:0]) * 64'(b[31:0]);
        p.lh = 64'(a[31:0]) * 64'(b[MW-1:32]);
        p.hl = 64'(a[MW-1:32]) * 64'(b[31:0]);
        p.hh = 64'(a[MW-1:32]) * 64'(b[MW-1:32]);
        return p;
    endfunction

    // floor(a*b / 2^32), saturated
    function automatic logic [MW-1:0] mul_fin(input t_pp p);
        logic [127:0] s;
        s = 128'(p.ll) + (128'(p.lh) << 32) + (128'(p.hl) << 32) + (128'(p.hh) << 64);
        return (s[127:32] > 96'(CAP)) ? CAP : s[MW+31:32];
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/tsf_src.sv =====
`default_nettype none
module tsf_src (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic                          i_mirror,
    input  wire logic signed [tsf_pkg::FW-1:0] i_pos [3],
    input  wire logic signed [tsf_pkg::FW-1:0] i_sp [3],
    input  wire logic [tsf_pkg::CW-1:0]        i_core,
    input  wire logic [tsf_pkg::CW-1:0]        i_mass,
    output logic signed [tsf_pkg::MW:0]        o_t [3],
    output logic [tsf_pkg::MW-1:0]             o_p
);
    localparam int AW = tsf_pkg::AW;
    localparam int MW = tsf_pkg::MW;
    localparam int RW = tsf_pkg::RW;
    localparam int QW = tsf_pkg::QW;
    localparam int LAT = tsf_pkg::LAT;
    localparam int SQ_ST = tsf_pkg::SQ_ST;
    localparam int DV_ST = tsf_pkg::DV_ST;
    localparam int PD_N = 7;
    localparam int FW_TOP = tsf_pkg::FW - 1;

    logic [AW-1:0]    r_ad [LAT-2][3];
    logic [2:0]       r_nd [LAT-1];
    tsf_pkg::t_pp     r_sqp [3];
    logic [MW-1:0]    r_sq [3];
    logic [MW-1:0]    r_r2;
    logic [MW-1:0]    r_sx [SQ_ST];
    logic [RW-1:0]    r_sroot [SQ_ST];
    logic [RW+2:0]    r_srem [SQ_ST];
    logic [RW-1:0]    r_dd [DV_ST];
    logic [QW-1:0]    r_dq [DV_ST];
    logic [QW-1:0]    r_drem [DV_ST];
    logic [MW-1:0]    r_f, r_f1, r_f2, r_ff, r_fff, r_g;
    tsf_pkg::t_pp     r_ppff, r_ppmf, r_ppfff, r_ppg;
    tsf_pkg::t_pp     r_ppt [3];
    logic [MW-1:0]    r_pd [PD_N];

    logic [AW-1:0]    n_a [3];
    logic [2:0]       n_neg;
    logic [63:0]      n_r2sum;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            logic signed [AW-1:0] d;
            d = i_mirror ? ({i_pos[c][FW_TOP], i_pos[c]} + {i_sp[c][FW_TOP], i_sp[c]})
                         : ({i_pos[c][FW_TOP], i_pos[c]} - {i_sp[c][FW_TOP], i_sp[c]});
            n_neg[c] = d[AW-1];
            n_a[c] = d[AW-1] ? AW'(-d) : AW'(d);
        end
        n_r2sum = 64'(i_core) + 64'(r_sq[0]) + 64'(r_sq[1]) + 64'(r_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ad[0] <= n_a;
            r_nd[0] <= n_neg;
            for (int k = 1; k < LAT - 2; k++) r_ad[k] <= r_ad[k-1];
            for (int k = 1; k < LAT - 1; k++) r_nd[k] <= r_nd[k-1];
            for (int c = 0; c < 3; c++) begin
                r_sqp[c] <= tsf_pkg::mul_pp(MW'(r_ad[0][c]), MW'(r_ad[0][c]));
                r_sq[c] <= tsf_pkg::mul_fin(r_sqp[c]);
            end
            r_r2 <= (n_r2sum > 64'(tsf_pkg::CAP)) ? tsf_pkg::CAP : n_r2sum[MW-1:0];
        end
    end

    // square root, SQ_PER result bits a stage
    for (genvar j = 0; j < SQ_ST; j++) begin : g_sq
        logic [MW-1:0] w_x;
        logic [RW-1:0] w_root, n_root;
        logic [RW+2:0] w_rem, n_rem;
        if (j == 0) begin : g_first
            assign w_x = r_r2;
            assign w_root = '0;
            assign w_rem = '0;
        end else begin : g_next
            assign w_x = r_sx[j-1];
            assign w_root = r_sroot[j-1];
            assign w_rem = r_srem[j-1];
        end
        always_comb begin : p_step
            logic [95:0]    x96;
            logic [RW+2:0]  rem;
            logic [RW+1:0]  trial;
            logic [RW-1:0]  root;
            int k;
            x96 = 96'({w_x, 32'b0});
            rem = w_rem;
            root = w_root;
            for (int i = 0; i < tsf_pkg::SQ_PER; i++) begin
                k = RW - 1 - (j * tsf_pkg::SQ_PER + i);
                rem = {rem[RW:0], x96[2*k +: 2]};
                trial = {root, 2'b01};
                if (rem >= (RW+3)'(trial)) begin
                    rem = rem - (RW+3)'(trial);
                    root = {root[RW-2:0], 1'b1};
                end else begin
                    root = {root[RW-2:0], 1'b0};
                end
            end
            n_root = root;
            n_rem = rem;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sx[j] <= w_x;
                r_sroot[j] <= n_root;
                r_srem[j] <= n_rem;
            end
        end
    end

    // 2^64 / r, DV_PER quotient bits a stage; r >= 2^16 unless r2 is zero
    for (genvar j = 0; j < DV_ST; j++) begin : g_dv
        logic [RW-1:0] w_d;
        logic [QW-1:0] w_q, w_rem, n_q, n_rem;
        if (j == 0) begin : g_first
            assign w_d = r_sroot[SQ_ST-1];
            assign w_q = '0;
            assign w_rem = QW'(1) << (tsf_pkg::DIVIDEND_LOG2 - QW);
        end else begin : g_next
            assign w_d = r_dd[j-1];
            assign w_q = r_dq[j-1];
            assign w_rem = r_drem[j-1];
        end
        always_comb begin : p_step
            logic [QW:0]   t;
            logic [QW-1:0] rem;
            logic [QW-1:0] q;
            rem = w_rem;
            q = w_q;
            for (int i = 0; i < tsf_pkg::DV_PER; i++) begin
                if (j * tsf_pkg::DV_PER + i < QW) begin
                    t = {rem, 1'b0};
                    if (t >= (QW+1)'(w_d)) begin
                        t = t - (QW+1)'(w_d);
                        q = {q[QW-2:0], 1'b1};
                    end else begin
                        q = {q[QW-2:0], 1'b0};
                    end
                    rem = t[QW-1:0];
                end
            end
            n_q = q;
            n_rem = rem;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dd[j] <= w_d;
                r_dq[j] <= n_q;
                r_drem[j] <= n_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f <= (r_dd[DV_ST-1] == '0) ? tsf_pkg::CAP : MW'(r_dq[DV_ST-1]);
            r_ppff <= tsf_pkg::mul_pp(r_f, r_f);
            r_ppmf <= tsf_pkg::mul_pp(MW'(i_mass), r_f);
            r_f1 <= r_f;
            r_ff <= tsf_pkg::mul_fin(r_ppff);
            r_pd[0] <= tsf_pkg::mul_fin(r_ppmf);
            for (int k = 1; k < PD_N; k++) r_pd[k] <= r_pd[k-1];
            r_f2 <= r_f1;
            r_ppfff <= tsf_pkg::mul_pp(r_ff, r_f2);
            r_fff <= tsf_pkg::mul_fin(r_ppfff);
            r_ppg <= tsf_pkg::mul_pp(MW'(i_mass), r_fff);
            r_g <= tsf_pkg::mul_fin(r_ppg);
            for (int c = 0; c < 3; c++) begin
                r_ppt[c] <= tsf_pkg::mul_pp(r_g, MW'(r_ad[LAT-3][c]));
                o_t[c] <= r_nd[LAT-2][c] ? $signed({1'b0, tsf_pkg::mul_fin(r_ppt[c])})
                                          : -$signed({1'b0, tsf_pkg::mul_fin(r_ppt[c])});
            end
        end
    end

    assign o_p = r_pd[PD_N-1];
endmodule
`default_nettype wire

// ===== hw/rtl/twin_satellite_softened_force_core.sv =====
`default_nettype none
// channel   dir  handshake              payload
// s_*       in   s_tvalid / s_tready    pos x/y/z, acc_in x/y/z, pot_in; tuser frozen; tlast
// m_*       out  m_tvalid / m_tready    acc_out x/y/z, pot_out; tlast
// APB       in   psel/penable/pwrite    5 registers on 64-bit data, byte address 8*index
//
// One request per cycle while the output is not held; the path runs through the
// 16-stage root and 13-stage reciprocal pipes and then the output register.
// Synchronous active-low reset clears valids and loads register defaults.
// A held output stalls the whole pipe; s_tready is low only then.
module twin_satellite_softened_force_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [5:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // pos_x, pos_y, pos_z, acc_in_x, acc_in_y, acc_in_z, pot_in
    input  wire logic [335:0] s_tdata,
    // frozen
    input  wire logic [0:0]   s_tuser,
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // acc_out_x, acc_out_y, acc_out_z, pot_out
    output logic [191:0]      m_tdata,
    output logic              m_tlast
);
    localparam int FW = tsf_pkg::FW;
    localparam int CW = tsf_pkg::CW;
    localparam int MW = tsf_pkg::MW;
    localparam int LAT = tsf_pkg::LAT;
    localparam logic signed [63:0] S_MAX = (64'sd1 <<< (FW - 1)) - 64'sd1;
    localparam logic signed [63:0] S_MIN = -(64'sd1 <<< (FW - 1));

    logic [CW-1:0]        r_core, r_mass;
    logic signed [FW-1:0] r_sp [3];
    logic [LAT-1:0]       r_vld, r_fr, r_last;
    logic signed [FW-1:0] r_acc [LAT][3];
    logic signed [FW-1:0] r_pot [LAT];
    logic                 r_o_vld, r_o_last;
    logic [191:0]         r_o_data;

    logic                 w_en;
    logic signed [FW-1:0] w_pos [3];
    logic signed [FW-1:0] w_acc [3];
    logic signed [MW:0]   w_t0 [3], w_t1 [3];
    logic [MW-1:0]        w_p0, w_p1;
    logic [191:0]         n_data;

    function automatic logic [FW-1:0] clamp(input logic signed [63:0] v);
        if (v > S_MAX) return FW'(S_MAX);
        if (v < S_MIN) return FW'(S_MIN);
        return v[FW-1:0];
    endfunction

    assign pready = 1'b1;
    assign w_en = !r_o_vld || m_tready;
    assign s_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core <= CW'(64'd1073741824);
            r_mass <= '0;
            r_sp[0] <= '0;
            r_sp[1] <= '0;
            r_sp[2] <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[5:3])
                tsf_pkg::REG_CORE: r_core <= pwdata[CW-1:0];
                tsf_pkg::REG_MASS: r_mass <= pwdata[CW-1:0];
                tsf_pkg::REG_SPX:  r_sp[0] <= pwdata[FW-1:0];
                tsf_pkg::REG_SPY:  r_sp[1] <= pwdata[FW-1:0];
                tsf_pkg::REG_SPZ:  r_sp[2] <= pwdata[FW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            tsf_pkg::REG_CORE: prdata = 64'(r_core);
            tsf_pkg::REG_MASS: prdata = 64'(r_mass);
            tsf_pkg::REG_SPX:  prdata = 64'($unsigned(r_sp[0]));
            tsf_pkg::REG_SPY:  prdata = 64'($unsigned(r_sp[1]));
            tsf_pkg::REG_SPZ:  prdata = 64'($unsigned(r_sp[2]));
            default:           prdata = '0;
        endcase
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_pos[c] = s_tdata[FW*c +: FW];
            w_acc[c] = s_tdata[FW*(3+c) +: FW];
        end
    end

    tsf_src u_src0 (
        .i_clk(i_clk), .i_en(w_en), .i_mirror(1'b0), .i_pos(w_pos), .i_sp(r_sp),
        .i_core(r_core), .i_mass(r_mass), .o_t(w_t0), .o_p(w_p0)
    );

    tsf_src u_src1 (
        .i_clk(i_clk), .i_en(w_en), .i_mirror(1'b1), .i_pos(w_pos), .i_sp(r_sp),
        .i_core(r_core), .i_mass(r_mass), .o_t(w_t1), .o_p(w_p1)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_acc[0] <= w_acc;
            r_pot[0] <= s_tdata[FW*6 +: FW];
            r_fr[0] <= s_tuser[0];
            r_last[0] <= s_tlast;
            for (int k = 1; k < LAT; k++) begin
                r_acc[k] <= r_acc[k-1];
                r_pot[k] <= r_pot[k-1];
                r_fr[k] <= r_fr[k-1];
                r_last[k] <= r_last[k-1];
            end
        end
    end

    always_comb begin
        logic signed [63:0] s;
        for (int c = 0; c < 3; c++) begin
            s = 64'(r_acc[LAT-1][c]) + 64'(w_t0[c]) + 64'(w_t1[c]);
            n_data[FW*c +: FW] = r_fr[LAT-1] ? r_acc[LAT-1][c] : clamp(s);
        end
        s = 64'(r_pot[LAT-1]) - $signed(64'(w_p0)) - $signed(64'(w_p1));
        n_data[FW*3 +: FW] = r_fr[LAT-1] ? r_pot[LAT-1] : clamp(s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_tvalid};
            r_o_vld <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_data <= n_data;
            r_o_last <= r_last[LAT-1];
        end
    end

    assign m_tvalid = r_o_vld;
    assign m_tdata = r_o_data;
    assign m_tlast = r_o_last;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipe valids moved during stall");

    a_frozen_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_vld[LAT-1] && r_fr[LAT-1]) |=>
        (m_tdata == $past({r_pot[LAT-1], r_acc[LAT-1][2], r_acc[LAT-1][1], r_acc[LAT-1][0]})))
        else $error("frozen request altered");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0) && !m_tvalid)
        else $error("valids not cleared by reset");
endmodule
`default_nettype wire
